>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property, switched off while reset is high.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   `ASSERT_PROP(name, clk, rst, (expr), msg)

`endif

>>> src/hpid_pkg.sv
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared constants, codes and types of the heading PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hpid_pkg;

   // Fraction bits of angles, errors and velocity.
   localparam int ANGLE_FRAC_BITS = 12;

   // pi in Q32, rounded to ANGLE_FRAC_BITS fraction bits.
   localparam logic [63:0] PI_Q32 = 64'd13493037705;
   localparam int PI_SCALED =
      int'((PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));
   localparam logic signed [17:0] PI_ERR     = 18'(PI_SCALED);
   localparam logic signed [17:0] TWO_PI_ERR = 18'(2 * PI_SCALED);

   // Field widths.
   localparam int ANGLE_W = 16;
   localparam int GAIN_W  = 20;
   localparam int TOL_W   = 15;
   localparam int TICK_W  = 16;
   localparam int ERR_W   = 17;
   localparam int DER_W   = 18;
   localparam int INTEG_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
   localparam int PROD_D_W = GAIN_W + 1 + DER_W;
   localparam int SUM_W    = PROD_I_W + 2;

   // Transaction kinds.
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_RUN     = 2'd0;
   localparam logic [1:0] STATUS_REACHED = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 3'd5;

   // Register reset values.
   localparam logic signed [ANGLE_W-1:0] TARGET_RST = 16'sd0;
   localparam logic [GAIN_W-1:0] GAIN_P_RST = 20'd52429;
   localparam logic [GAIN_W-1:0] GAIN_I_RST = 20'd20;
   localparam logic [GAIN_W-1:0] GAIN_D_RST = 20'd6554;
   localparam logic [TOL_W-1:0]  TOL_RST    = 15'd41;
   localparam logic [TICK_W-1:0] LIMIT_RST  = 16'd6000;

   // Regulator state carried from one sample to the next.
   typedef struct packed {
      logic signed [INTEG_W-1:0] integral;
      logic signed [ERR_W-1:0]   prev_err;
      logic [TICK_W-1:0]         elapsed;
      logic                      finished;
   } state_type;

   // Per-sample terms handed to the multiply stage.
   typedef struct packed {
      logic                      hold;
      logic [1:0]                status;
      logic signed [ERR_W-1:0]   err;
      logic signed [INTEG_W-1:0] integral;
      logic signed [DER_W-1:0]   deriv;
   } step_type;

   // Registered products handed to the sum stage.
   typedef struct packed {
      logic                       hold;
      logic [1:0]                 status;
      logic signed [PROD_P_W-1:0] prod_p;
      logic signed [PROD_I_W-1:0] prod_i;
      logic signed [PROD_D_W-1:0] prod_d;
   } prod_type;

endpackage

`default_nettype wire

>>> src/heading_pid_controller.sv
// ----------------------------------------------------------------------------
// heading_pid_controller: registers input, step, multiply and output stages.
// One transaction per cycle is taken unless the result stalls on rsp_ready.
// Synchronous reset loads register defaults and clears the regulator state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module heading_pid_controller (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_kind,
   input  wire logic signed [hpid_pkg::ANGLE_W-1:0]    req_current_angle,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [hpid_pkg::ANGLE_W-1:0]         rsp_velocity_cmd,
   output logic [1:0]                                  rsp_status,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [hpid_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [hpid_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import hpid_pkg::*;

   localparam logic signed [SUM_W-1:0] VEL_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] VEL_MIN = -SUM_W'(32768);
   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(32768);

   // Configuration registers.
   logic signed [ANGLE_W-1:0] target_ff;
   logic [GAIN_W-1:0]         gain_p_ff;
   logic [GAIN_W-1:0]         gain_i_ff;
   logic [GAIN_W-1:0]         gain_d_ff;
   logic [TOL_W-1:0]          tol_ff;
   logic [TICK_W-1:0]         limit_ff;

   // Pipeline registers.
   logic                      in_vld_ff;
   logic                      in_kind_ff;
   logic signed [ANGLE_W-1:0] in_angle_ff;
   logic                      s1_vld_ff;
   step_type                  s1_step_ff;
   logic                      s2_vld_ff;
   prod_type                  s2_prod_ff;
   prod_type                  s2_prod_in;
   logic                      rsp_vld_ff;
   logic signed [ANGLE_W-1:0] rsp_vel_ff;
   logic signed [ANGLE_W-1:0] rsp_vel_in;
   logic [1:0]                rsp_status_ff;

   // Regulator state.
   state_type                 state_ff;
   state_type                 state_in;
   step_type                  step;

   logic                      out_rdy;
   logic                      s2_rdy;
   logic                      s1_rdy;
   logic                      s1_take;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   scaled;

   // Each stage moves on when the stage after it is empty or moving.
   assign out_rdy   = !rsp_vld_ff || rsp_ready;
   assign s2_rdy    = !s2_vld_ff || out_rdy;
   assign s1_rdy    = !s1_vld_ff || s2_rdy;
   assign req_ready = !in_vld_ff || s1_rdy;
   assign s1_take   = in_vld_ff && s1_rdy;
   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RST;
         gain_p_ff <= GAIN_P_RST;
         gain_i_ff <= GAIN_I_RST;
         gain_d_ff <= GAIN_D_RST;
         tol_ff    <= TOL_RST;
         limit_ff  <= LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TARGET: target_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_GAIN_P: gain_p_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I: gain_i_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D: gain_d_ff <= csr_wdata[GAIN_W-1:0];
            CSR_TOL:    tol_ff    <= csr_wdata[TOL_W-1:0];
            CSR_LIMIT:  limit_ff  <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_kind_ff  <= req_kind;
         in_angle_ff <= req_current_angle;
      end
   end

   // Error, decision and state update.
   hpid_step u_step (
      .kind          (in_kind_ff),
      .current_angle (in_angle_ff),
      .target_angle  (target_ff),
      .tolerance     (tol_ff),
      .tick_limit    (limit_ff),
      .state_cur     (state_ff),
      .state_next    (state_in),
      .step          (step)
   );

   // The state advances once per transaction, as it enters the step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            state_ff <= state_in;
         end
         if (s1_rdy) begin
            s1_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_step_ff <= step;
      end
   end

   // Gain products.
   always_comb begin
      s2_prod_in.hold   = s1_step_ff.hold;
      s2_prod_in.status = s1_step_ff.status;
      s2_prod_in.prod_p = $signed({1'b0, gain_p_ff}) * s1_step_ff.err;
      s2_prod_in.prod_i = $signed({1'b0, gain_i_ff}) * s1_step_ff.integral;
      s2_prod_in.prod_d = $signed({1'b0, gain_d_ff}) * s1_step_ff.deriv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_vld_ff) begin
         s2_prod_ff <= s2_prod_in;
      end
   end

   // Sum, round half up by 16 bits and saturate to 16 bits; a held result is zero.
   always_comb begin
      sum = SUM_W'(s2_prod_ff.prod_p) + SUM_W'(s2_prod_ff.prod_i)
          + SUM_W'(s2_prod_ff.prod_d) + HALF_LSB;
      scaled = sum >>> 16;
      if (s2_prod_ff.hold) begin
         rsp_vel_in = '0;
      end else if (scaled > VEL_MAX) begin
         rsp_vel_in = VEL_MAX[ANGLE_W-1:0];
      end else if (scaled < VEL_MIN) begin
         rsp_vel_in = VEL_MIN[ANGLE_W-1:0];
      end else begin
         rsp_vel_in = scaled[ANGLE_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && s2_vld_ff) begin
         rsp_vel_ff    <= rsp_vel_in;
         rsp_status_ff <= s2_prod_ff.status;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_velocity_cmd = rsp_vel_ff;
   assign rsp_status       = rsp_status_ff;

   // Checks on the regulator logic.
   `ASSERT_ALWAYS(a_done_zero, clock, reset,
      !rsp_vld_ff || rsp_status_ff == STATUS_RUN || rsp_vel_ff == '0,
      "done status with nonzero velocity")
   `ASSERT_ALWAYS(a_status_code, clock, reset,
      !rsp_vld_ff || rsp_status_ff == STATUS_RUN || rsp_status_ff == STATUS_REACHED
      || rsp_status_ff == STATUS_TIMEOUT, "invalid status code")
   `ASSERT_PROP(a_start_clears, clock, reset,
      (s1_take && in_kind_ff == KIND_START) |=> (state_ff == '0),
      "start transaction did not clear the state")
   `ASSERT_PROP(a_state_hold, clock, reset,
      !s1_take |=> $stable(state_ff), "state changed without a transaction")

endmodule

`default_nettype wire

>>> src/hpid_step.sv
// ----------------------------------------------------------------------------
// hpid_step
// Error wrap, done decision and state update for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module hpid_step (
   input  wire logic                                     kind,
   input  wire logic signed [hpid_pkg::ANGLE_W-1:0]      current_angle,
   input  wire logic signed [hpid_pkg::ANGLE_W-1:0]      target_angle,
   input  wire logic [hpid_pkg::TOL_W-1:0]               tolerance,
   input  wire logic [hpid_pkg::TICK_W-1:0]              tick_limit,
   input  wire hpid_pkg::state_type                      state_cur,
   output hpid_pkg::state_type                           state_next,
   output hpid_pkg::step_type                            step
);
   import hpid_pkg::*;

   logic signed [DER_W-1:0]   diff;
   logic signed [DER_W-1:0]   wrapped;
   logic signed [ERR_W-1:0]   err;
   logic [ERR_W-1:0]          err_abs;
   logic                      near;
   logic                      late;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_sat;
   logic signed [DER_W-1:0]   deriv;

   // Heading error, wrapped once into plus or minus pi.
   always_comb begin
      diff = DER_W'(target_angle) - DER_W'(current_angle);
      if (diff > PI_ERR) begin
         wrapped = diff - TWO_PI_ERR;
      end else if (diff < -PI_ERR) begin
         wrapped = diff + TWO_PI_ERR;
      end else begin
         wrapped = diff;
      end
      err = wrapped[ERR_W-1:0];
      err_abs = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   end

   // Done conditions.
   assign near = err_abs < ERR_W'(tolerance);
   assign late = state_cur.finished || (state_cur.elapsed > tick_limit);

   // Saturating integral and error difference.
   always_comb begin
      integ_sum = (INTEG_W+1)'(state_cur.integral) + (INTEG_W+1)'(err);
      if (integ_sum > $signed({2'b00, {(INTEG_W-1){1'b1}}})) begin
         integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
      end else if (integ_sum < $signed({2'b11, {(INTEG_W-1){1'b0}}})) begin
         integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
      deriv = DER_W'(err) - DER_W'(state_cur.prev_err);
   end

   // Result terms and next state.
   always_comb begin
      state_next    = state_cur;
      step.hold     = 1'b1;
      step.status   = STATUS_RUN;
      step.err      = err;
      step.integral = integ_sat;
      step.deriv    = deriv;
      if (kind == KIND_START) begin
         state_next = '0;
      end else if (near) begin
         step.status         = STATUS_REACHED;
         state_next.finished = 1'b1;
      end else if (late) begin
         step.status         = STATUS_TIMEOUT;
         state_next.finished = 1'b1;
      end else begin
         step.hold           = 1'b0;
         state_next.integral = integ_sat;
         state_next.prev_err = err;
         if (state_cur.elapsed != {TICK_W{1'b1}}) begin
            state_next.elapsed = state_cur.elapsed + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the heading PID controller. A scoreboard class
// predicts the velocity command and status of every accepted transaction and
// checks each result in order. Directed transactions cover the angle wrap,
// tolerance and time limit. Random phases then run under several register
// settings and handshake pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import hpid_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 12;
   localparam int LIMIT_CYCLES = 200_000;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 70;
   localparam int REPORT_LIMIT = 10;

   // pi and 2*pi in Q3.12 at the width of the raw error.
   localparam logic signed [17:0] HALF_TURN = 18'sd12868;
   localparam logic signed [17:0] FULL_TURN = 18'sd25736;

   // Register indexes past the last register; writes to them are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [ANGLE_W-1:0] velocity;
      logic [1:0]                status;
   } command_type;

   // Predicts the regulator output and checks results against it.
   class velocity_scoreboard;
      logic signed [ANGLE_W-1:0] target;
      logic [GAIN_W-1:0]         kp;
      logic [GAIN_W-1:0]         ki;
      logic [GAIN_W-1:0]         kd;
      logic [TOL_W-1:0]          tol;
      logic [TICK_W-1:0]         limit;
      logic signed [INTEG_W-1:0] integral;
      logic signed [ERR_W-1:0]   prev_err;
      logic [TICK_W-1:0]         elapsed;
      logic                      finished;
      command_type               queued_commands[$];
      int                        failures;
      int                        checked;

      function new();
         target = 16'sd0;
         kp = 20'd52429;
         ki = 20'd20;
         kd = 20'd6554;
         tol = 15'd41;
         limit = 16'd6000;
         clear_run();
         failures = 0;
         checked = 0;
      endfunction

      function void clear_run();
         integral = '0;
         prev_err = '0;
         elapsed = '0;
         finished = 1'b0;
      endfunction

      function void fail(string msg);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TARGET: target = data[ANGLE_W-1:0];
            CSR_GAIN_P: kp = data;
            CSR_GAIN_I: ki = data;
            CSR_GAIN_D: kd = data;
            CSR_TOL:    tol = data[TOL_W-1:0];
            CSR_LIMIT:  limit = data[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      // One PID step for an accepted transaction; queues the expected command.
      function void record_request(logic kind, logic signed [ANGLE_W-1:0] angle);
         logic signed [17:0]       err;
         logic [17:0]              mag;
         logic signed [33:0]       integ_sum;
         logic signed [DER_W-1:0]  deriv;
         logic signed [63:0]       acc;
         logic signed [63:0]       vel;
         command_type              cmd;
         cmd.velocity = '0;
         cmd.status = STATUS_RUN;
         if (kind == KIND_START) begin
            clear_run();
            queued_commands.push_back(cmd);
            return;
         end

         // Error wrapped once into plus or minus pi.
         err = target - angle;
         if (err > HALF_TURN)
            err = err - FULL_TURN;
         else if (err < -HALF_TURN)
            err = err + FULL_TURN;
         mag = (err < 0) ? -err : err;

         // Tolerance takes precedence over the time limit.
         if (mag < tol)
            cmd.status = STATUS_REACHED;
         else if (finished || elapsed > limit)
            cmd.status = STATUS_TIMEOUT;
         if (cmd.status != STATUS_RUN) begin
            finished = 1'b1;
            queued_commands.push_back(cmd);
            return;
         end

         // Saturating integral, then the three products summed exactly.
         integ_sum = integral + err;
         if (integ_sum > 34'sd2147483647)
            integ_sum = 34'sd2147483647;
         else if (integ_sum < -34'sd2147483648)
            integ_sum = -34'sd2147483648;
         integral = integ_sum[INTEG_W-1:0];
         deriv = err - prev_err;
         acc = $signed({1'b0, kp}) * err + $signed({1'b0, ki}) * integral
             + $signed({1'b0, kd}) * deriv;
         vel = (acc + 64'sd32768) >>> 16;
         if (vel > 64'sd32767)
            cmd.velocity = 16'sh7FFF;
         else if (vel < -64'sd32768)
            cmd.velocity = 16'sh8000;
         else
            cmd.velocity = vel[ANGLE_W-1:0];

         prev_err = err[ERR_W-1:0];
         if (elapsed != '1)
            elapsed++;
         queued_commands.push_back(cmd);
      endfunction

      function void check_result(logic signed [ANGLE_W-1:0] velocity, logic [1:0] status);
         command_type cmd;
         if (queued_commands.size() == 0) begin
            fail($sformatf("unexpected result: velocity %0d status %0d", velocity, status));
            return;
         end
         cmd = queued_commands.pop_front();
         checked++;
         if (velocity !== cmd.velocity)
            fail($sformatf("result %0d velocity: expected %0d, got %0d",
                           checked, cmd.velocity, velocity));
         if (status !== cmd.status)
            fail($sformatf("result %0d status: expected %0d, got %0d",
                           checked, cmd.status, status));
      endfunction

      function void check_drained();
         if (queued_commands.size() != 0)
            fail($sformatf("%0d expected results never arrived", queued_commands.size()));
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_kind;
   logic signed [ANGLE_W-1:0] req_current_angle;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [ANGLE_W-1:0] rsp_velocity_cmd;
   logic [1:0]                rsp_status;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   velocity_scoreboard        sb;
   int                        send_idle_pct;
   int                        recv_idle_pct;
   int                        accepted;
   logic signed [ANGLE_W-1:0] aim_setting;
   int                        tol_setting;

   heading_pid_controller u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_current_angle (req_current_angle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_velocity_cmd  (rsp_velocity_cmd),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("Timed out waiting for the block");
      $display("Regression FAIL");
      $finish;
   end

   // Every handshake is observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            sb.record_request(req_kind, req_current_angle);
            accepted++;
         end
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_velocity_cmd, rsp_status);
      end
   end

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(input logic kind, input logic signed [ANGLE_W-1:0] angle);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_current_angle <= angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop sending and wait until every expected result has been checked.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.queued_commands.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_setting(input logic signed [ANGLE_W-1:0] aim,
                                input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                                input logic [GAIN_W-1:0] d, input logic [TOL_W-1:0] tol,
                                input logic [TICK_W-1:0] lim);
      write_csr(CSR_TARGET, 20'(aim));
      write_csr(CSR_GAIN_P, p);
      write_csr(CSR_GAIN_I, i);
      write_csr(CSR_GAIN_D, d);
      write_csr(CSR_TOL, 20'(tol));
      write_csr(CSR_LIMIT, 20'(lim));
      aim_setting = aim;
      tol_setting = int'(tol);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      if ($urandom_range(2) == 0)
         return 20'($urandom);
      return 20'($urandom_range(70000));
   endfunction

   // Angles near the target, near the wrap points, at the extremes or anywhere.
   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int pick;
      int span;
      int off;
      pick = $urandom_range(99);
      span = (tol_setting > 2000) ? 2000 : tol_setting + 8;
      if (pick < 35)
         return 16'($urandom);
      if (pick < 75) begin
         off = $urandom_range(2 * span) - span;
         return 16'(aim_setting + off);
      end
      if (pick < 92) begin
         off = int'(HALF_TURN) + $urandom_range(4) - 2;
         return $urandom_range(1) ? 16'(aim_setting - off) : 16'(aim_setting + off);
      end
      return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
   endfunction

   task automatic run_directed();
      // Reset settings: target 0, tolerance 41, limit 6000.
      send_item(KIND_SAMPLE, 16'sd1000);
      send_item(KIND_SAMPLE, -16'sd32768);
      send_item(KIND_SAMPLE, 16'sd32767);
      send_item(KIND_SAMPLE, -16'sd12868);
      send_item(KIND_SAMPLE, -16'sd12869);
      send_item(KIND_SAMPLE, 16'sd12868);
      send_item(KIND_SAMPLE, 16'sd12869);
      send_item(KIND_SAMPLE, -16'sd41);
      send_item(KIND_SAMPLE, 16'sd40);
      // Once finished, samples report only done status.
      send_item(KIND_SAMPLE, 16'sd5000);
      send_item(KIND_SAMPLE, 16'sd0);
      send_item(KIND_START, 16'sd32767);
      send_item(KIND_SAMPLE, 16'sd200);
      send_item(KIND_SAMPLE, 16'sd100);
      wait_idle();

      // Writes past the last register must change nothing.
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, 20'($urandom));
      write_csr(CSR_TOL, 20'd0);
      write_csr(CSR_LIMIT, 20'd1);
      tol_setting = 0;
      send_item(KIND_START, -16'sd32768);
      send_item(KIND_SAMPLE, 16'sd3000);
      send_item(KIND_SAMPLE, 16'sd2000);
      send_item(KIND_SAMPLE, 16'sd1000);
      wait_idle();

      // Both done conditions at once: tolerance wins.
      write_csr(CSR_LIMIT, 20'd0);
      write_csr(CSR_TOL, 20'd100);
      tol_setting = 100;
      send_item(KIND_START, 16'sd0);
      send_item(KIND_SAMPLE, 16'sd3000);
      send_item(KIND_SAMPLE, 16'sd50);
      wait_idle();
   endtask

   task automatic run_phase(input int phase);
      int count;
      int len;
      if (phase < 3) begin
         send_idle_pct = 32;
         recv_idle_pct = 63;
      end else if (phase < 6) begin
         send_idle_pct = 63;
         recv_idle_pct = 32;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      wait_idle();
      if ($urandom_range(1))
         write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, 20'($urandom));
      case (phase)
         0: write_setting(16'sh7FFF, '1, '1, '1, '1, '1);
         1: write_setting(16'sh8000, '0, '0, '0, '0, '0);
         default: write_setting(16'($urandom), pick_gain(), pick_gain(), pick_gain(),
                                15'($urandom_range(300)),
                                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)));
      endcase

      // Mostly runs of samples from a start; the rest is loose transactions.
      count = 0;
      while (count < PHASE_ITEMS) begin
         if ($urandom_range(99) < 85) begin
            len = $urandom_range(30, 1);
            send_item(KIND_START, 16'($urandom));
            repeat (len) send_item(KIND_SAMPLE, pick_angle());
            count += len + 1;
         end else begin
            len = $urandom_range(4, 1);
            repeat (len) send_item(1'($urandom_range(1)), 16'($urandom));
            count += len;
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_START;
      req_current_angle = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_TARGET;
      csr_wdata = '0;
      send_idle_pct = 32;
      recv_idle_pct = 63;
      accepted = 0;
      aim_setting = '0;
      tol_setting = 41;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      for (int phase = 0; phase < PHASES; phase++)
         run_phase(phase);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_drained();
      $display("Covered %0d transactions: directed wrap, tolerance and time limit cases,",
               accepted);
      $display("%0d random register settings under three handshake patterns; %0d checked",
               PHASES, sb.checked);
      if (sb.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
